// ===== design/pwl_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the piecewise-linear decompanding pixel unit.
package pwl_pkg;

	localparam int MAX_KNEES     = 8;
	localparam int IN_BITS       = 12;
	localparam int OUT_BITS      = 20;
	localparam int RAW_BITS      = 16;
	localparam int NARROW_SHIFT  = 4;
	localparam int KNEE_CNT_BITS = 4;
	localparam int KNEE_IDX_BITS = $clog2(MAX_KNEES);

	// input knees: two 48-bit registers of four knees each
	localparam int IN_PER_REG  = 4;
	localparam int IN_REG_BITS = IN_PER_REG * IN_BITS;

	// output knees: one RAM row per register, three knees a row, two in the last row
	localparam int KNEES_PER_ROW = 3;
	localparam int OUT_ROWS      = 3;
	localparam int ROW_BITS      = KNEES_PER_ROW * OUT_BITS;
	localparam int LAST_ROW_BITS = 2 * OUT_BITS;
	localparam int ROW_ADDR_BITS = $clog2(OUT_ROWS);
	localparam int LANE_BITS     = $clog2(KNEES_PER_ROW);

	// divider: product magnitude stays below 2^(IN_BITS+OUT_BITS)
	localparam int DVD_BITS = IN_BITS + OUT_BITS;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = ROW_BITS;

	localparam logic [KNEE_CNT_BITS-1:0] KNEE_CNT_MIN = KNEE_CNT_BITS'(2);
	localparam logic [KNEE_CNT_BITS-1:0] KNEE_CNT_MAX = KNEE_CNT_BITS'(MAX_KNEES);
	localparam logic [KNEE_CNT_BITS-1:0] KNEE_CNT_RST = KNEE_CNT_BITS'(2);
	localparam logic [IN_REG_BITS-1:0]   IN_LOW_RST   = IN_REG_BITS'(48'hFFF000);
	localparam logic [IN_REG_BITS-1:0]   IN_HIGH_RST  = '0;
	localparam logic [ROW_BITS-1:0]      OUT_FIRST_RST = ROW_BITS'(60'hFFF00000);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODE       = 3'd0,
		REG_SAMPLE16   = 3'd1,
		REG_KNEE_COUNT = 3'd2,
		REG_IN_LOW     = 3'd3,
		REG_IN_HIGH    = 3'd4,
		REG_OUT_FIRST  = 3'd5,
		REG_OUT_MIDDLE = 3'd6,
		REG_OUT_LAST   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		RES_LINEAR = 2'd0,
		RES_KNEE   = 2'd1,
		RES_INTERP = 2'd2,
		RES_ZERO   = 2'd3
	} res_kind_t;

	// travels alongside the division
	typedef struct packed {
		res_kind_t             kind;
		logic [OUT_BITS-1:0]   base;
		logic                  neg;
		logic                  frame_end;
	} pwl_side_t;

	function automatic logic [ROW_ADDR_BITS-1:0] knee_row(input logic [KNEE_IDX_BITS-1:0] k);
		logic [ROW_ADDR_BITS-1:0] r;
		if (k < KNEE_IDX_BITS'(KNEES_PER_ROW))
			r = ROW_ADDR_BITS'(0);
		else if (k < KNEE_IDX_BITS'(2 * KNEES_PER_ROW))
			r = ROW_ADDR_BITS'(1);
		else
			r = ROW_ADDR_BITS'(2);
		return r;
	endfunction

	function automatic logic [LANE_BITS-1:0] knee_lane(input logic [KNEE_IDX_BITS-1:0] k);
		logic [ROW_ADDR_BITS-1:0] r;
		logic [KNEE_IDX_BITS-1:0] off;
		r   = knee_row(k);
		off = KNEE_IDX_BITS'(r) * KNEE_IDX_BITS'(KNEES_PER_ROW);
		return LANE_BITS'(k - off);
	endfunction

	function automatic logic [ROW_BITS-1:0] out_row_rst(input logic [ROW_ADDR_BITS-1:0] row);
		return (row == ROW_ADDR_BITS'(0)) ? OUT_FIRST_RST : '0;
	endfunction

endpackage

// ===== design/pwl_in_if.sv =====
`timescale 1ns / 1ps
// Raw pixel input channel.
interface pwl_in_if;
	logic                          valid;
	logic                          ready;
	logic [pwl_pkg::RAW_BITS-1:0]  raw_pixel;
	logic                          frame_end_in;

	modport source (output valid, raw_pixel, frame_end_in, input ready);
	modport sink   (input valid, raw_pixel, frame_end_in, output ready);
endinterface

// ===== design/pwl_out_if.sv =====
`timescale 1ns / 1ps
// Linear pixel output channel.
interface pwl_out_if;
	logic                          valid;
	logic                          ready;
	logic [pwl_pkg::OUT_BITS-1:0]  linear_pixel;
	logic                          frame_end_out;

	modport source (output valid, linear_pixel, frame_end_out, input ready);
	modport sink   (input valid, linear_pixel, frame_end_out, output ready);
endinterface

// ===== design/pwl_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
module pwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                        rdata_a,
	output logic [WIDTH-1:0]                        rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== design/pwl_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with side data.
module pwl_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [pwl_pkg::DVD_BITS-1:0]    dividend,
	input  logic [pwl_pkg::IN_BITS-1:0]     divisor,
	input  pwl_pkg::pwl_side_t              in_side,
	output logic                            out_valid,
	output logic [pwl_pkg::OUT_BITS-1:0]    quotient,
	output logic                            rem_nz,
	output pwl_pkg::pwl_side_t              out_side
);

	localparam int STEPS = pwl_pkg::OUT_BITS;
	localparam int DW    = pwl_pkg::DVD_BITS;
	localparam int XW    = pwl_pkg::IN_BITS;

	logic [STEPS:0]          vld_q;
	logic [DW-1:0]           rem_q  [STEPS+1];
	logic [STEPS-1:0]        quo_q  [STEPS+1];
	logic [XW-1:0]           dsr_q  [STEPS+1];
	pwl_pkg::pwl_side_t      side_q [STEPS+1];

	logic [DW-1:0]           trial  [STEPS];
	logic [DW-1:0]           rem_nx [STEPS];
	logic [STEPS-1:0]        quo_nx [STEPS];

	// stage i settles quotient bit STEPS-1-i
	always_comb begin
		for (int i = 0; i < STEPS; i++) begin
			trial[i]  = DW'(dsr_q[i]) << (STEPS - 1 - i);
			rem_nx[i] = rem_q[i];
			quo_nx[i] = quo_q[i];
			if (rem_q[i] >= trial[i]) begin
				rem_nx[i] = rem_q[i] - trial[i];
				quo_nx[i][STEPS - 1 - i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[STEPS-1:0], in_valid};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= dividend;
			quo_q[0]  <= '0;
			dsr_q[0]  <= divisor;
			side_q[0] <= in_side;
			for (int i = 0; i < STEPS; i++) begin
				rem_q[i+1]  <= rem_nx[i];
				quo_q[i+1]  <= quo_nx[i];
				dsr_q[i+1]  <= dsr_q[i];
				side_q[i+1] <= side_q[i];
			end
		end
	end

	assign out_valid = vld_q[STEPS];
	assign quotient  = quo_q[STEPS];
	assign rem_nz    = |rem_q[STEPS];
	assign out_side  = side_q[STEPS];

endmodule

// ===== design/pwl_decompand_pixel_unit.sv =====
`timescale 1ns / 1ps
// Top level: piecewise-linear decompanding of one raw pixel per transaction.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+------------------------------------------
//  pix_in    | in  | valid/ready  | raw_pixel[15:0], frame_end_in
//  pix_out   | out | valid/ready  | linear_pixel[19:0], frame_end_out
//  cfg       | in  | cfg_we       | cfg_index[2:0], cfg_data[59:0]
//
// One transaction per clock sustained while the skid entry stays empty; each result
// passes the RAM read, slope stage, multiplier, then 20 divider stages of
// one quotient bit each, then the output register.
// arst_n resets the configuration registers and clears the knee-row valid bits; an
// unwritten output-knee row reads as its reset value, so no clearing pass is run.
// A two-entry output buffer (output register plus skid) lets pix_out stall
// without loss; pix_in.ready drops only while the skid entry is full.
module pwl_decompand_pixel_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	pwl_in_if.sink                              pix_in,
	pwl_out_if.source                           pix_out,
	input  logic                                cfg_we,
	input  logic [pwl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [pwl_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int IB = pwl_pkg::IN_BITS;
	localparam int OB = pwl_pkg::OUT_BITS;
	localparam int NK = pwl_pkg::MAX_KNEES;
	localparam int KB = pwl_pkg::KNEE_IDX_BITS;
	localparam int RA = pwl_pkg::ROW_ADDR_BITS;
	localparam int LB = pwl_pkg::LANE_BITS;
	localparam int RB = pwl_pkg::ROW_BITS;

	// ---------------------------------------------------------------- config
	logic                               mode_q;
	logic                               s16_q;
	logic [pwl_pkg::KNEE_CNT_BITS-1:0]  knee_cnt_q;
	logic [pwl_pkg::IN_REG_BITS-1:0]    in_low_q;
	logic [pwl_pkg::IN_REG_BITS-1:0]    in_high_q;
	logic [pwl_pkg::OUT_ROWS-1:0]       row_vld_q;

	pwl_pkg::cfg_reg_t                  cfg_reg;
	logic                               row_we;
	logic [RA-1:0]                      row_waddr;
	logic [RB-1:0]                      row_wdata;

	assign cfg_reg = pwl_pkg::cfg_reg_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			s16_q      <= 1'b0;
			knee_cnt_q <= pwl_pkg::KNEE_CNT_RST;
			in_low_q   <= pwl_pkg::IN_LOW_RST;
			in_high_q  <= pwl_pkg::IN_HIGH_RST;
			row_vld_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg) inside
				pwl_pkg::REG_MODE:       mode_q     <= cfg_data[0];
				pwl_pkg::REG_SAMPLE16:   s16_q      <= cfg_data[0];
				pwl_pkg::REG_KNEE_COUNT: knee_cnt_q <= cfg_data[pwl_pkg::KNEE_CNT_BITS-1:0];
				pwl_pkg::REG_IN_LOW:     in_low_q   <= cfg_data[pwl_pkg::IN_REG_BITS-1:0];
				pwl_pkg::REG_IN_HIGH:    in_high_q  <= cfg_data[pwl_pkg::IN_REG_BITS-1:0];
				pwl_pkg::REG_OUT_FIRST,
				pwl_pkg::REG_OUT_MIDDLE,
				pwl_pkg::REG_OUT_LAST:   row_vld_q[row_waddr] <= 1'b1;
				default: ;
			endcase
		end
	end

	// output knees live in the RAM, one config register per row
	always_comb begin
		row_we    = cfg_we && (cfg_reg == pwl_pkg::REG_OUT_FIRST ||
		                       cfg_reg == pwl_pkg::REG_OUT_MIDDLE ||
		                       cfg_reg == pwl_pkg::REG_OUT_LAST);
		row_waddr = RA'(cfg_index - pwl_pkg::REG_OUT_FIRST);
		row_wdata = cfg_data;
		if (cfg_reg == pwl_pkg::REG_OUT_LAST)
			row_wdata = RB'(cfg_data[pwl_pkg::LAST_ROW_BITS-1:0]);
	end

	// ---------------------------------------------------------------- flow control
	logic en;
	logic skid_vld_q;
	logic acc;

	assign en           = !skid_vld_q;
	assign pix_in.ready = en;
	assign acc          = pix_in.valid && en;

	// ---------------------------------------------------------------- stage 0
	logic [IB-1:0]                      ink [NK];
	logic [IB-1:0]                      v;
	logic [IB-1:0]                      sat12;
	logic [OB-1:0]                      lin;
	logic [pwl_pkg::KNEE_CNT_BITS-1:0]  n_c;
	logic [KB-1:0]                      nm1;
	logic                               below;
	logic                               above;
	logic                               fnd;
	logic [KB-1:0]                      seg;
	logic [KB-1:0]                      seg_nx;
	logic [KB-1:0]                      ka;
	logic [KB-1:0]                      kb;
	pwl_pkg::res_kind_t                 kind;

	always_comb begin
		for (int k = 0; k < NK; k++) begin
			if (k < pwl_pkg::IN_PER_REG)
				ink[k] = in_low_q[k*IB +: IB];
			else
				ink[k] = in_high_q[(k - pwl_pkg::IN_PER_REG)*IB +: IB];
		end
	end

	always_comb begin
		// an oversized 12-bit sample saturates in both modes
		sat12 = (|pix_in.raw_pixel[pwl_pkg::RAW_BITS-1:IB]) ? '1 : pix_in.raw_pixel[IB-1:0];
		v     = s16_q ? pix_in.raw_pixel[pwl_pkg::RAW_BITS-1:pwl_pkg::NARROW_SHIFT] : sat12;
		if (s16_q)
			lin = OB'(pix_in.raw_pixel);
		else
			lin = OB'({sat12, {pwl_pkg::NARROW_SHIFT{1'b0}}});

		n_c = knee_cnt_q;
		if (knee_cnt_q < pwl_pkg::KNEE_CNT_MIN)
			n_c = pwl_pkg::KNEE_CNT_MIN;
		else if (knee_cnt_q > pwl_pkg::KNEE_CNT_MAX)
			n_c = pwl_pkg::KNEE_CNT_MAX;
		nm1 = KB'(n_c - 1'b1);

		below = v < ink[0];
		above = v >= ink[nm1];

		// highest rising segment holding v wins
		fnd = 1'b0;
		seg = '0;
		for (int j = 0; j < NK - 1; j++) begin
			if (KB'(j) < nm1 && ink[j] <= v && v < ink[j+1]) begin
				fnd = 1'b1;
				seg = KB'(j);
			end
		end
		seg_nx = seg + 1'b1;

		ka = seg;
		kb = seg_nx;
		if (below) begin
			ka = '0;
			kb = '0;
		end else if (above) begin
			ka = nm1;
			kb = nm1;
		end

		if (mode_q)
			kind = pwl_pkg::RES_LINEAR;
		else if (below || above)
			kind = pwl_pkg::RES_KNEE;
		else if (fnd)
			kind = pwl_pkg::RES_INTERP;
		else
			kind = pwl_pkg::RES_ZERO;
	end

	logic [RB-1:0] ram_a;
	logic [RB-1:0] ram_b;

	pwl_ram #(
		.WIDTH (RB),
		.DEPTH (pwl_pkg::OUT_ROWS)
	) u_knee_ram (
		.clk     (clk),
		.we      (row_we),
		.waddr   (row_waddr),
		.wdata   (row_wdata),
		.re      (en),
		.raddr_a (pwl_pkg::knee_row(ka)),
		.raddr_b (pwl_pkg::knee_row(kb)),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	// ---------------------------------------------------------------- stage 1
	logic                v_s1;
	pwl_pkg::res_kind_t  kind_s1;
	logic [OB-1:0]       lin_s1;
	logic [RA-1:0]       row_a_s1;
	logic [RA-1:0]       row_b_s1;
	logic [LB-1:0]       lane_a_s1;
	logic [LB-1:0]       lane_b_s1;
	logic                vld_a_s1;
	logic                vld_b_s1;
	logic [IB-1:0]       dvx_s1;
	logic [IB-1:0]       dx_s1;
	logic                fe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= kind;
			lin_s1    <= lin;
			row_a_s1  <= pwl_pkg::knee_row(ka);
			row_b_s1  <= pwl_pkg::knee_row(kb);
			lane_a_s1 <= pwl_pkg::knee_lane(ka);
			lane_b_s1 <= pwl_pkg::knee_lane(kb);
			vld_a_s1  <= row_vld_q[pwl_pkg::knee_row(ka)];
			vld_b_s1  <= row_vld_q[pwl_pkg::knee_row(kb)];
			dvx_s1    <= v - ink[seg];
			dx_s1     <= ink[seg_nx] - ink[seg];
			fe_s1     <= pix_in.frame_end_in;
		end
	end

	logic [RB-1:0]       row_a;
	logic [RB-1:0]       row_b;
	logic [OB-1:0]       ya;
	logic [OB-1:0]       yb;
	logic                down;
	logic [OB-1:0]       ady;
	pwl_pkg::pwl_side_t  side_s1;

	always_comb begin
		row_a = vld_a_s1 ? ram_a : pwl_pkg::out_row_rst(row_a_s1);
		row_b = vld_b_s1 ? ram_b : pwl_pkg::out_row_rst(row_b_s1);
		ya    = row_a[lane_a_s1*OB +: OB];
		yb    = row_b[lane_b_s1*OB +: OB];
		down  = yb < ya;
		ady   = down ? (ya - yb) : (yb - ya);

		side_s1.kind      = kind_s1;
		side_s1.base      = (kind_s1 == pwl_pkg::RES_LINEAR) ? lin_s1 : ya;
		side_s1.neg       = down;
		side_s1.frame_end = fe_s1;
	end

	// ---------------------------------------------------------------- stage 2
	logic                v_s2;
	pwl_pkg::pwl_side_t  side_s2;
	logic [IB-1:0]       dvx_s2;
	logic [OB-1:0]       ady_s2;
	logic [IB-1:0]       dx_s2;
	logic [pwl_pkg::DVD_BITS-1:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			dvx_s2  <= dvx_s1;
			ady_s2  <= ady;
			dx_s2   <= dx_s1;
		end
	end

	// |(v - x0) * (y1 - y0)|, registered at the divider's input
	assign prod = pwl_pkg::DVD_BITS'(dvx_s2) * pwl_pkg::DVD_BITS'(ady_s2);

	// ---------------------------------------------------------------- divider
	logic                div_vld;
	logic [OB-1:0]       div_q;
	logic                div_rnz;
	pwl_pkg::pwl_side_t  div_side;

	pwl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.dividend  (prod),
		.divisor   (dx_s2),
		.in_side   (side_s2),
		.out_valid (div_vld),
		.quotient  (div_q),
		.rem_nz    (div_rnz),
		.out_side  (div_side)
	);

	// ---------------------------------------------------------------- result
	logic signed [OB+1:0] sum;
	logic [OB-1:0]        interp;
	logic [OB-1:0]        res_pix;
	logic                 push;

	always_comb begin
		// floored quotient: a negative slope with a remainder rounds one further down
		if (div_side.neg)
			sum = $signed({2'b00, div_side.base}) - $signed({2'b00, div_q})
			      - $signed((OB+2)'(div_rnz));
		else
			sum = $signed({2'b00, div_side.base}) + $signed({2'b00, div_q});

		if (sum < 0)
			interp = '0;
		else if (sum > $signed({2'b00, {OB{1'b1}}}))
			interp = '1;
		else
			interp = sum[OB-1:0];

		case (div_side.kind)
			pwl_pkg::RES_INTERP: res_pix = interp;
			pwl_pkg::RES_ZERO:   res_pix = '0;
			default:             res_pix = div_side.base;
		endcase
	end

	assign push = en && div_vld;

	// ---------------------------------------------------------------- output buffer
	logic          out_vld_q;
	logic [OB-1:0] out_pix_q;
	logic          out_fe_q;
	logic [OB-1:0] skid_pix_q;
	logic          skid_fe_q;
	logic          pop;

	assign pop = out_vld_q && pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_vld_q) begin
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= push;
				end
			end else if (!out_vld_q) begin
				out_vld_q <= push;
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_vld_q) begin
			out_pix_q <= skid_pix_q;
			out_fe_q  <= skid_fe_q;
		end else if (pop || !out_vld_q) begin
			out_pix_q <= res_pix;
			out_fe_q  <= div_side.frame_end;
		end
		if (!pop && out_vld_q && push) begin
			skid_pix_q <= res_pix;
			skid_fe_q  <= div_side.frame_end;
		end
	end

	assign pix_out.valid         = out_vld_q;
	assign pix_out.linear_pixel  = out_pix_q;
	assign pix_out.frame_end_out = out_fe_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the piecewise-linear decompanding pixel unit.
module testbench;

	localparam int IN_BITS       = pwl_pkg::IN_BITS;
	localparam int OUT_BITS      = pwl_pkg::OUT_BITS;
	localparam int RAW_BITS      = pwl_pkg::RAW_BITS;
	localparam int MAX_KNEES     = pwl_pkg::MAX_KNEES;
	localparam int NARROW_SHIFT  = pwl_pkg::NARROW_SHIFT;
	localparam int KNEE_CNT_BITS = pwl_pkg::KNEE_CNT_BITS;
	localparam int IN_REG_BITS   = pwl_pkg::IN_REG_BITS;
	localparam int ROW_BITS      = pwl_pkg::ROW_BITS;
	localparam int LAST_ROW_BITS = pwl_pkg::LAST_ROW_BITS;
	localparam int CFG_IDX_BITS  = pwl_pkg::CFG_IDX_BITS;
	localparam int CFG_DATA_BITS = pwl_pkg::CFG_DATA_BITS;

	// depth of the unit's pipe, used for the final settling wait
	localparam int PIPE_DEPTH   = 23;
	// long receiver hold-off, long enough to fill the pipe and the skid
	localparam int LONG_HOLD    = 400;
	// cycles with no transaction on either channel before the run is abandoned
	localparam int QUIET_LIMIT  = 4000;
	localparam int N_DIRECTED   = 37;
	localparam int N_PHASES     = 8;
	localparam int PHASE_ITEMS  = 50;
	localparam int MAX_REPORTS  = 10;
	localparam longint IN_MAX   = (64'd1 << IN_BITS) - 1;
	localparam longint OUT_TOP  = (64'd1 << OUT_BITS) - 1;

	// one pixel offered to the unit; a typed expectation rides along where it is obvious
	typedef struct packed {
		logic [RAW_BITS-1:0] raw;
		logic                frame_end;
		logic                typed;
		logic [OUT_BITS-1:0] want;
	} pixel_item_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] linear_pixel;
		logic                frame_end;
	} pixel_res_t;

	// directed stimulus row: either a register write or a pixel
	typedef struct packed {
		logic                     is_reg;
		pwl_pkg::cfg_reg_t        idx;
		logic [CFG_DATA_BITS-1:0] data;
		pixel_item_t              pix;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	pwl_in_if  pix_in ();
	pwl_out_if pix_out ();

	pwl_decompand_pixel_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the configuration, updated on every register write
	logic                     cur_mode;
	logic                     cur_s16;
	logic [KNEE_CNT_BITS-1:0] cur_kcnt;
	logic [IN_REG_BITS-1:0]   cur_in_lo;
	logic [IN_REG_BITS-1:0]   cur_in_hi;
	logic [ROW_BITS-1:0]      cur_out_first;
	logic [ROW_BITS-1:0]      cur_out_middle;
	logic [LAST_ROW_BITS-1:0] cur_out_last;

	pixel_item_t raw_backlog[$];   // pixels waiting to be offered
	pixel_res_t  linear_due[$];    // results owed by the unit, oldest first
	pixel_item_t on_bus;
	pixel_res_t  due_res;
	dir_row_t    directed_tbl[N_DIRECTED];

	int n_queued;
	int n_taken;
	int mism_cnt;
	int burst_left;
	int gap_left;
	int hold_left;
	int ready_pct;
	int style_left;
	int press_reqs;
	int press_seen;
	int quiet_cycles;

	always #10 clk = ~clk;

	function automatic longint in_knee_of(input int k);
		logic [2*IN_REG_BITS-1:0] all_in;
		all_in = {cur_in_hi, cur_in_lo};
		return longint'(all_in[k*IN_BITS +: IN_BITS]);
	endfunction

	function automatic longint out_knee_of(input int k);
		logic [2*ROW_BITS+LAST_ROW_BITS-1:0] all_out;
		all_out = {cur_out_last, cur_out_middle, cur_out_first};
		return longint'(all_out[k*OUT_BITS +: OUT_BITS]);
	endfunction

	// predicted linear_pixel for one raw sample under the current configuration
	function automatic logic [OUT_BITS-1:0] decompand_pixel(input logic [RAW_BITS-1:0] raw);
		longint v, x0, x1, y0, y1, num, den, r;
		int n, seg;
		// 12-bit samples above full scale saturate in both modes
		v = (!cur_s16 && longint'(raw) > IN_MAX) ? IN_MAX : longint'(raw);
		if (cur_mode) begin
			if (!cur_s16)
				v = v << NARROW_SHIFT;
			return OUT_BITS'(v);
		end
		if (cur_s16)
			v = v >> NARROW_SHIFT;
		n = int'(cur_kcnt);
		if (n < 2)
			n = 2;
		if (n > MAX_KNEES)
			n = MAX_KNEES;
		if (v < in_knee_of(0))
			return OUT_BITS'(out_knee_of(0));
		if (v >= in_knee_of(n - 1))
			return OUT_BITS'(out_knee_of(n - 1));
		// highest rising segment that holds v wins
		seg = -1;
		for (int j = 0; j + 1 < n; j++) begin
			if (in_knee_of(j) <= v && v < in_knee_of(j + 1))
				seg = j;
		end
		r = 0;
		if (seg >= 0) begin
			x0  = in_knee_of(seg);
			x1  = in_knee_of(seg + 1);
			y0  = out_knee_of(seg);
			y1  = out_knee_of(seg + 1);
			num = (v - x0) * (y1 - y0);
			den = x1 - x0;
			// floored quotient, falling segments give a negative product
			r = y0 + ((num >= 0) ? num / den : -((-num + den - 1) / den));
		end
		if (r < 0)
			r = 0;
		if (r > OUT_TOP)
			r = OUT_TOP;
		return OUT_BITS'(r);
	endfunction

	function automatic dir_row_t pixel_row(input logic [RAW_BITS-1:0] raw, input logic fe);
		dir_row_t r;
		r               = '0;
		r.pix.raw       = raw;
		r.pix.frame_end = fe;
		return r;
	endfunction

	function automatic dir_row_t checked_row(input logic [RAW_BITS-1:0] raw, input logic fe,
			input logic [OUT_BITS-1:0] want);
		dir_row_t r;
		r           = pixel_row(raw, fe);
		r.pix.typed = 1'b1;
		r.pix.want  = want;
		return r;
	endfunction

	function automatic dir_row_t reg_row(input pwl_pkg::cfg_reg_t idx,
			input logic [CFG_DATA_BITS-1:0] d);
		dir_row_t r;
		r        = '0;
		r.is_reg = 1'b1;
		r.idx    = idx;
		r.data   = d;
		return r;
	endfunction

	// random sample: mostly close to a knee, some full-range noise and the rails
	function automatic logic [RAW_BITS-1:0] pick_raw();
		longint x;
		logic [RAW_BITS-1:0] r;
		case ($urandom_range(0, 7))
			0, 1: begin
				r = RAW_BITS'($urandom);
			end
			2: begin
				r = $urandom_range(0, 1) ? '1 : '0;
			end
			default: begin
				x = in_knee_of($urandom_range(0, MAX_KNEES - 1)) + longint'($urandom_range(0, 4)) - 2;
				if (x < 0)
					x = 0;
				if (x > IN_MAX)
					x = IN_MAX;
				if (cur_s16)
					r = {x[IN_BITS-1:0], 4'($urandom)};
				else if ($urandom_range(0, 5) == 0)
					r = RAW_BITS'(x) | 16'h1000;   // oversized 12-bit sample
				else
					r = RAW_BITS'(x);
			end
		endcase
		return r;
	endfunction

	task automatic queue_pixel(input pixel_item_t it);
		raw_backlog.push_back(it);
		n_queued++;
	endtask

	// pipe empty and every owed result in; the unit can take a register write
	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_taken != n_queued || linear_due.size() != 0);
	endtask

	task automatic put_reg(input pwl_pkg::cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			pwl_pkg::REG_MODE:       cur_mode       = d[0];
			pwl_pkg::REG_SAMPLE16:   cur_s16        = d[0];
			pwl_pkg::REG_KNEE_COUNT: cur_kcnt       = d[KNEE_CNT_BITS-1:0];
			pwl_pkg::REG_IN_LOW:     cur_in_lo      = d[IN_REG_BITS-1:0];
			pwl_pkg::REG_IN_HIGH:    cur_in_hi      = d[IN_REG_BITS-1:0];
			pwl_pkg::REG_OUT_FIRST:  cur_out_first  = d;
			pwl_pkg::REG_OUT_MIDDLE: cur_out_middle = d;
			pwl_pkg::REG_OUT_LAST:   cur_out_last   = d[LAST_ROW_BITS-1:0];
			default: ;
		endcase
	endtask

	// Sender: offers the backlog in bursts of random length with random gaps.
	// An offered pixel stays on the bus until taken; its result is predicted
	// at the edge of the input transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_in.valid && pix_in.ready) begin
				n_taken++;
				if (on_bus.typed)
					linear_due.push_back('{on_bus.want, on_bus.frame_end});
				else
					linear_due.push_back('{decompand_pixel(on_bus.raw), on_bus.frame_end});
			end
			if (!pix_in.valid || pix_in.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					pix_in.valid <= 1'b0;
				end else if (raw_backlog.size() > 0) begin
					on_bus = raw_backlog.pop_front();
					pix_in.valid        <= 1'b1;
					pix_in.raw_pixel    <= on_bus.raw;
					pix_in.frame_end_in <= on_bus.frame_end;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 32);
						gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					pix_in.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks every output transaction against the oldest owed result,
	// and stalls with a duty cycle that is drawn anew at random intervals.
	// A press request from the main flow turns into one long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_out.valid && pix_out.ready) begin
				if (linear_due.size() == 0) begin
					mism_cnt++;
					if (mism_cnt <= MAX_REPORTS)
						$display("unexpected result: linear_pixel %h frame_end %0b",
							pix_out.linear_pixel, pix_out.frame_end_out);
				end else begin
					due_res = linear_due.pop_front();
					if (pix_out.linear_pixel !== due_res.linear_pixel ||
							pix_out.frame_end_out !== due_res.frame_end) begin
						mism_cnt++;
						if (mism_cnt <= MAX_REPORTS)
							$display("mismatch: linear_pixel exp %h got %h, frame_end exp %0b got %0b",
								due_res.linear_pixel, pix_out.linear_pixel,
								due_res.frame_end, pix_out.frame_end_out);
					end
				end
			end
			if (press_seen != press_reqs) begin
				press_seen = press_reqs;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_out.ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					case ($urandom_range(0, 3))
						0: ready_pct = 100;
						1: ready_pct = 75;
						2: ready_pct = 40;
						default: ready_pct = 10;
					endcase
					style_left = $urandom_range(20, 150);
				end else begin
					style_left--;
				end
				pix_out.ready <= ($urandom_range(0, 99) < ready_pct);
			end
		end
	end

	// Watchdog: quiet stretches on both channels beyond the limit end the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic                     md, s16;
		logic [KNEE_CNT_BITS-1:0] kc;
		logic [IN_REG_BITS-1:0]   in_lo, in_hi;
		logic [ROW_BITS-1:0]      o_first, o_middle;
		logic [LAST_ROW_BITS-1:0] o_last;
		logic [2*IN_REG_BITS-1:0] in_all;
		int                       kq[$];
		pixel_item_t              it;

		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = pwl_pkg::REG_MODE;
		cfg_data            = '0;
		pix_in.valid        = 1'b0;
		pix_in.raw_pixel    = '0;
		pix_in.frame_end_in = 1'b0;
		pix_out.ready       = 1'b0;
		n_queued     = 0;
		n_taken      = 0;
		mism_cnt     = 0;
		burst_left   = 0;
		gap_left     = 0;
		hold_left    = 0;
		ready_pct    = 100;
		style_left   = 0;
		press_reqs   = 0;
		press_seen   = 0;
		quiet_cycles = 0;

		// reset values of the registers
		cur_mode       = 1'b0;
		cur_s16        = 1'b0;
		cur_kcnt       = pwl_pkg::KNEE_CNT_RST;
		cur_in_lo      = pwl_pkg::IN_LOW_RST;
		cur_in_hi      = pwl_pkg::IN_HIGH_RST;
		cur_out_first  = pwl_pkg::OUT_FIRST_RST;
		cur_out_middle = '0;
		cur_out_last   = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Reset curve is the identity over 0..4095.
		directed_tbl = '{
			checked_row(16'h0000, 1'b0, 20'h00000),
			checked_row(16'h0FFF, 1'b1, 20'h00FFF),   // at the last knee
			checked_row(16'hFFFF, 1'b0, 20'h00FFF),   // oversized 12-bit sample
			checked_row(16'h1000, 1'b1, 20'h00FFF),
			pixel_row(16'h0AAA, 1'b0),
			// linear passthrough, 12-bit: shifted up
			reg_row(pwl_pkg::REG_MODE, 60'd1),
			checked_row(16'hFFFF, 1'b1, 20'h0FFF0),   // saturates before the shift
			checked_row(16'h0ABC, 1'b0, 20'h0ABC0),
			// linear passthrough, 16-bit: untouched
			reg_row(pwl_pkg::REG_SAMPLE16, 60'd1),
			checked_row(16'hFFFF, 1'b1, 20'h0FFFF),
			checked_row(16'h0000, 1'b0, 20'h00000),
			checked_row(16'h5A5A, 1'b1, 20'h05A5A),
			// decompand of 16-bit samples: top 12 bits through the identity curve
			reg_row(pwl_pkg::REG_MODE, 60'd0),
			checked_row(16'hFFFF, 1'b0, 20'h00FFF),
			checked_row(16'h1234, 1'b1, 20'h00123),
			// eight-knee curve with one falling segment
			reg_row(pwl_pkg::REG_SAMPLE16, 60'd0),
			reg_row(pwl_pkg::REG_KNEE_COUNT, 60'd8),
			reg_row(pwl_pkg::REG_IN_LOW, 60'h600_400_200_100),
			reg_row(pwl_pkg::REG_IN_HIGH, 60'hE00_C00_A00_800),
			reg_row(pwl_pkg::REG_OUT_FIRST, 60'h04000_00800_00010),
			reg_row(pwl_pkg::REG_OUT_MIDDLE, 60'h40000_0C000_10000),
			reg_row(pwl_pkg::REG_OUT_LAST, 60'hFFFFF_80000),
			checked_row(16'h00FF, 1'b0, 20'h00010),   // below the first knee
			checked_row(16'h0E00, 1'b1, 20'hFFFFF),   // at the last knee
			checked_row(16'hFFFF, 1'b0, 20'hFFFFF),
			pixel_row(16'h0150, 1'b0),
			pixel_row(16'h07FF, 1'b1),                // falling segment
			pixel_row(16'h0DFF, 1'b0),
			// knee count below range is taken as two
			reg_row(pwl_pkg::REG_KNEE_COUNT, 60'd0),
			checked_row(16'h0300, 1'b0, 20'h00800),
			// knee count above range is taken as eight
			reg_row(pwl_pkg::REG_KNEE_COUNT, 60'd15),
			pixel_row(16'h0C10, 1'b1),
			// unordered input knees: highest rising segment holding v
			reg_row(pwl_pkg::REG_KNEE_COUNT, 60'd4),
			reg_row(pwl_pkg::REG_IN_LOW, 60'h300_100_800_000),
			pixel_row(16'h0200, 1'b0),
			pixel_row(16'h0050, 1'b1),
			checked_row(16'h07FF, 1'b0, 20'h10000)
		};

		foreach (directed_tbl[i]) begin
			if (directed_tbl[i].is_reg) begin
				wait_drained();
				put_reg(directed_tbl[i].idx, directed_tbl[i].data);
			end else begin
				queue_pixel(directed_tbl[i].pix);
			end
		end

		// Random phases, each with a fresh configuration. The early phases hit
		// the extremes: fewest knees, most knees, all-ones and all-zero knees,
		// then linear passthrough of both sample widths.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_drained();
			md  = 1'($urandom_range(0, 3) == 0);
			s16 = 1'($urandom);
			if (ph == 4 || ph == 5) begin
				md  = 1'b1;
				s16 = (ph == 5);
			end
			case (ph)
				0: kc = pwl_pkg::KNEE_CNT_MIN;
				1: kc = pwl_pkg::KNEE_CNT_MAX;
				3: kc = '1;
				default: kc = KNEE_CNT_BITS'($urandom_range(0, 15));
			endcase
			if (ph == 2) begin
				in_all   = '1;
				o_first  = '1;
				o_middle = '1;
				o_last   = '1;
			end else if (ph == 3) begin
				in_all   = '0;
				o_first  = '0;
				o_middle = '0;
				o_last   = '0;
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					in_all = {$urandom, $urandom, $urandom};
				end else begin
					// rising knees, now and then a flat step
					kq.delete();
					repeat (MAX_KNEES) kq.push_back($urandom_range(0, int'(IN_MAX)));
					kq.sort();
					if ($urandom_range(0, 2) == 0)
						kq[4] = kq[3];
					for (int k = 0; k < MAX_KNEES; k++)
						in_all[k*IN_BITS +: IN_BITS] = IN_BITS'(kq[k]);
				end
				o_first  = ROW_BITS'({$urandom, $urandom});
				o_middle = ROW_BITS'({$urandom, $urandom});
				o_last   = LAST_ROW_BITS'({$urandom, $urandom});
			end
			in_lo = in_all[IN_REG_BITS-1:0];
			in_hi = in_all[2*IN_REG_BITS-1:IN_REG_BITS];
			put_reg(pwl_pkg::REG_MODE, CFG_DATA_BITS'(md));
			put_reg(pwl_pkg::REG_SAMPLE16, CFG_DATA_BITS'(s16));
			put_reg(pwl_pkg::REG_KNEE_COUNT, CFG_DATA_BITS'(kc));
			put_reg(pwl_pkg::REG_IN_LOW, CFG_DATA_BITS'(in_lo));
			put_reg(pwl_pkg::REG_IN_HIGH, CFG_DATA_BITS'(in_hi));
			put_reg(pwl_pkg::REG_OUT_FIRST, o_first);
			put_reg(pwl_pkg::REG_OUT_MIDDLE, o_middle);
			put_reg(pwl_pkg::REG_OUT_LAST, CFG_DATA_BITS'(o_last));
			// one long hold-off on the output while the whole phase is offered
			if (ph == 1)
				press_reqs++;
			repeat (PHASE_ITEMS) begin
				it           = '0;
				it.raw       = pick_raw();
				it.frame_end = ($urandom_range(0, 7) == 0);
				queue_pixel(it);
			end
		end

		wait_drained();
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (mism_cnt == 0 && linear_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== pwl_decompand_pixel_unit.f =====
design/pwl_pkg.sv
design/pwl_in_if.sv
design/pwl_out_if.sv
design/pwl_ram.sv
design/pwl_div.sv
design/pwl_decompand_pixel_unit.sv
sim/testbench.sv
